### hw/rtl/sld_pkg.sv
// ----------------------------------------------------------------------------
// sld_pkg: shared types and constants of the sync/length/sum deframer
// Sync bytes, phase and sequencer codes, register indexes and the records
// passed between the parser front end, the frame queue and the drain side.
// ----------------------------------------------------------------------------
`default_nettype none

package sld_pkg;

	// Default storage limit of a frame in bytes
	localparam int MAX_FRAME_DEF = 64;

	// Frame buffers: one is filled while the other drains
	localparam int NUM_BANKS = 2;
	localparam int PW        = $clog2(NUM_BANKS);
	localparam int CW        = $clog2(NUM_BANKS + 1);

	localparam logic [7:0] SYNC_FIRST  = 8'h5A;
	localparam logic [7:0] SYNC_SECOND = 8'hA5;

	// Smallest and largest lengths that any frame may carry
	localparam logic [7:0] LEN_FLOOR = 8'd4;
	localparam logic [7:0] LEN_CEIL  = 8'd63;

	// Parser phases
	localparam logic [1:0] PH_HUNT   = 2'd0;
	localparam logic [1:0] PH_SECOND = 2'd1;
	localparam logic [1:0] PH_LENGTH = 2'd2;
	localparam logic [1:0] PH_BODY   = 2'd3;

	// Drain sequencer states
	localparam logic [1:0] BK_IDLE = 2'd0;
	localparam logic [1:0] BK_READ = 2'd1;
	localparam logic [1:0] BK_SEND = 2'd2;

	// Configuration register indexes
	localparam logic REG_MIN_LEN = 1'b0;
	localparam logic REG_MAX_LEN = 1'b1;

	localparam logic [5:0] MIN_LEN_RST = 6'd6;
	localparam logic [6:0] MAX_LEN_RST = 7'd64;

	// Write into the frame buffers
	typedef struct packed {
		logic       en;
		logic       bank;
		logic [5:0] idx;
		logic [7:0] data;
	} wr_t;

	// One checked frame waiting to be drained
	typedef struct packed {
		logic       bank;
		logic [5:0] len;
	} desc_t;

endpackage

`default_nettype wire

### hw/rtl/sync_length_sum_deframer.sv
// ----------------------------------------------------------------------------
// sync_length_sum_deframer: byte-stream frame recovery
// Parses 0x5A 0xA5 length payload checksum frames and forwards good ones.
//
// Input stream s_*: one received byte per request, taken whenever fewer than
// two checked frames are waiting; the parser accepts one byte per cycle.
// Output stream m_*: one frame byte per request with its position and the
// frame length; m_tlast marks the checksum byte. Frames failing the sync,
// length or checksum checks produce nothing.
// Once its checksum byte is taken, a good frame is queued, popped by the
// idle drain sequencer and read from its bank before its first byte is
// valid. Draining runs at one byte per cycle while m_tready stays high;
// between frames m_tvalid stays low for a queue pop and a buffer read.
// Two frame banks of up to 64 bytes let a new frame fill while the previous
// one drains. With both banks full, s_tready drops until the drain side
// finishes a frame; a stalled output simply holds the current byte.
// Configuration (cfg_we, cfg_addr, cfg_wdata): index 0 min_len, index 1
// max_len; write only while idle. Reset returns the parser to the hunt,
// empties the queue and loads min_len 6, max_len 64. No clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module sync_length_sum_deframer
	import sld_pkg::*;
#(
	parameter int MAX_FRAME = MAX_FRAME_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata,   // [7:0] frame_byte, [13:8] byte_pos,
	                                    // [19:14] total_len, [23:20] zero
	output logic             m_tlast,
	input  wire logic        cfg_we,
	input  wire logic        cfg_addr,
	input  wire logic [6:0]  cfg_wdata
);

	wr_t   mem_wr;
	logic  push;
	desc_t push_desc;
	logic  frame_done;
	logic  q_valid;
	desc_t q_desc;
	logic  q_pop;

	sld_front #(
		.MAX_FRAME(MAX_FRAME)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.mem_wr    (mem_wr),
		.push      (push),
		.push_desc (push_desc),
		.frame_done(frame_done)
	);

	sld_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_desc(push_desc),
		.pop      (q_pop),
		.q_valid  (q_valid),
		.q_desc   (q_desc)
	);

	sld_back #(
		.MAX_FRAME(MAX_FRAME)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.mem_wr    (mem_wr),
		.q_valid   (q_valid),
		.q_desc    (q_desc),
		.q_pop     (q_pop),
		.frame_done(frame_done),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule

`default_nettype wire

### hw/rtl/sld_front.sv
// ----------------------------------------------------------------------------
// sld_front: byte parser of the deframer
// Hunts the two sync bytes, checks the length byte, writes the frame into
// the current buffer bank and queues the frame once its checksum matches.
// ----------------------------------------------------------------------------
`default_nettype none

module sld_front
	import sld_pkg::*;
#(
	parameter int MAX_FRAME = MAX_FRAME_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,
	input  wire logic       cfg_we,
	input  wire logic       cfg_addr,
	input  wire logic [6:0] cfg_wdata,
	output wr_t             mem_wr,
	output logic            push,
	output desc_t           push_desc,
	input  wire logic       frame_done
);

	localparam logic [8:0] LEN_LIMIT = 9'(MAX_FRAME);

	logic [5:0]    min_len_q;
	logic [6:0]    max_len_q;
	logic [1:0]    phase_q, phase_d;
	logic [5:0]    fill_q, fill_d;
	logic [5:0]    exp_q, exp_d;
	logic [7:0]    sum_q, sum_d;
	logic          bank_q;
	logic [CW-1:0] pend_q;

	logic       accept;
	logic       store;
	logic       len_ok;
	logic [5:0] fill_nx;

	assign s_tready = pend_q < CW'(NUM_BANKS);
	assign accept   = s_tvalid && s_tready;
	assign fill_nx  = fill_q + 6'd1;

	assign len_ok = (s_tdata > {2'b00, min_len_q}) && ({1'b0, s_tdata} < {2'b00, max_len_q}) &&
		(s_tdata >= LEN_FLOOR) && (s_tdata <= LEN_CEIL) && ({1'b0, s_tdata} < LEN_LIMIT);

	always_comb begin
		phase_d = phase_q;
		fill_d  = fill_q;
		exp_d   = exp_q;
		sum_d   = sum_q;
		store   = 1'b0;
		push    = 1'b0;
		if (accept) begin
			case (phase_q)
				PH_SECOND: begin
					if (s_tdata == SYNC_SECOND) begin
						store   = 1'b1;
						fill_d  = fill_nx;
						sum_d   = sum_q + s_tdata;
						phase_d = PH_LENGTH;
					end else begin
						phase_d = PH_HUNT;
						fill_d  = '0;
						exp_d   = '0;
						sum_d   = '0;
					end
				end
				PH_LENGTH: begin
					if (len_ok) begin
						store   = 1'b1;
						fill_d  = fill_nx;
						sum_d   = sum_q + s_tdata;
						exp_d   = s_tdata[5:0];
						phase_d = PH_BODY;
					end else begin
						phase_d = PH_HUNT;
						fill_d  = '0;
						exp_d   = '0;
						sum_d   = '0;
					end
				end
				PH_BODY: begin
					store = 1'b1;
					if (fill_nx < exp_q) begin
						fill_d = fill_nx;
						sum_d  = sum_q + s_tdata;
					end else begin
						// checksum byte: queue the frame only when the sum matches
						push    = (sum_q == s_tdata);
						phase_d = PH_HUNT;
						fill_d  = '0;
						exp_d   = '0;
						sum_d   = '0;
					end
				end
				default: begin
					if (s_tdata == SYNC_FIRST) begin
						store   = 1'b1;
						fill_d  = 6'd1;
						sum_d   = s_tdata;
						phase_d = PH_SECOND;
					end else begin
						phase_d = PH_HUNT;
						fill_d  = '0;
						exp_d   = '0;
						sum_d   = '0;
					end
				end
			endcase
		end
	end

	always_comb begin
		mem_wr.en      = store;
		mem_wr.bank    = bank_q;
		mem_wr.idx     = fill_q;
		mem_wr.data    = s_tdata;
		push_desc.bank = bank_q;
		push_desc.len  = exp_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_len_q <= MIN_LEN_RST;
			max_len_q <= MAX_LEN_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_MIN_LEN: min_len_q <= cfg_wdata[5:0];
				REG_MAX_LEN: max_len_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			fill_q  <= '0;
			exp_q   <= '0;
			sum_q   <= '0;
			bank_q  <= 1'b0;
			pend_q  <= '0;
		end else begin
			phase_q <= phase_d;
			fill_q  <= fill_d;
			exp_q   <= exp_d;
			sum_q   <= sum_d;
			// switch banks once a frame is handed over
			if (push) begin
				bank_q <= ~bank_q;
			end
			case ({push, frame_done})
				2'b10:   pend_q <= pend_q + 1'b1;
				2'b01:   pend_q <= pend_q - 1'b1;
				default: pend_q <= pend_q;
			endcase
		end
	end

	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= CW'(NUM_BANKS))
		else $error("more frames pending than buffer banks");

	a_hunt_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_HUNT) |-> (fill_q == 6'd0 && sum_q == 8'd0))
		else $error("hunt phase with a partly filled frame");

	a_push_len: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (phase_q == PH_BODY && exp_q >= 6'd4 && fill_nx == exp_q))
		else $error("frame queued with an inconsistent length");

	a_done_pending: assert property (@(posedge clk) disable iff (!arst_n)
		frame_done |-> (pend_q != '0))
		else $error("frame drained with none pending");

endmodule

`default_nettype wire

### hw/rtl/sld_fifo.sv
// ----------------------------------------------------------------------------
// sld_fifo: queue of checked frames
// Holds the bank and length of each frame that the parser has accepted
// until the drain side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module sld_fifo
	import sld_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  desc_t      push_desc,
	input  wire logic  pop,
	output logic       q_valid,
	output desc_t      q_desc
);

	desc_t         entry_q [NUM_BANKS];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign q_valid = count_q != '0;
	assign q_desc  = entry_q[rd_ptr_q];
	assign do_push = push && (count_q != CW'(NUM_BANKS));
	assign do_pop  = pop && q_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(NUM_BANKS - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(NUM_BANKS - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

### hw/rtl/sld_back.sv
// ----------------------------------------------------------------------------
// sld_back: frame buffers and drain sequencer
// Holds two frame banks; takes a queued frame and streams its bytes out
// with position, length and end-of-frame mark.
// ----------------------------------------------------------------------------
`default_nettype none

module sld_back
	import sld_pkg::*;
#(
	parameter int MAX_FRAME = MAX_FRAME_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wr_t              mem_wr,
	input  wire logic        q_valid,
	input  desc_t            q_desc,
	output logic             q_pop,
	output logic             frame_done,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata,
	output logic             m_tlast
);

	localparam int DEPTH = (MAX_FRAME < 64) ? MAX_FRAME : 64;
	localparam int AW    = $clog2(DEPTH);
	// each bank spans a full power-of-two slot so {bank, index} stays in range
	localparam int SLOTS = 2 ** AW;

	logic [7:0] mem [NUM_BANKS * SLOTS];

	logic [1:0]  state_q;
	logic        bank_q;
	logic [5:0]  len_q;
	logic [5:0]  pos_q;
	logic        valid_q;
	logic [7:0]  rd_data_q;

	logic        out_acc;
	logic        last;
	logic        rd_en;
	logic [5:0]  rd_pos;
	logic [AW:0] rd_addr;
	logic [AW:0] wr_addr;

	assign out_acc = valid_q && m_tready;
	assign last    = (pos_q + 6'd1) == len_q;
	assign rd_en   = (state_q == BK_READ) || ((state_q == BK_SEND) && out_acc && !last);
	assign rd_pos  = (state_q == BK_READ) ? pos_q : pos_q + 6'd1;
	assign rd_addr = {bank_q, rd_pos[AW-1:0]};
	assign wr_addr = {mem_wr.bank, mem_wr.idx[AW-1:0]};

	assign q_pop      = (state_q == BK_IDLE) && q_valid;
	assign frame_done = (state_q == BK_SEND) && out_acc && last;

	assign m_tvalid = valid_q;
	assign m_tdata  = {4'b0000, len_q, pos_q, rd_data_q};
	assign m_tlast  = last;

	always_ff @(posedge clk) begin
		if (mem_wr.en && ({1'b0, mem_wr.idx} < 7'(DEPTH))) begin
			mem[wr_addr] <= mem_wr.data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			valid_q <= 1'b0;
			pos_q   <= '0;
			bank_q  <= 1'b0;
			len_q   <= '0;
		end else begin
			case (state_q)
				BK_IDLE: begin
					if (q_valid) begin
						bank_q  <= q_desc.bank;
						len_q   <= q_desc.len;
						pos_q   <= '0;
						state_q <= BK_READ;
					end
				end
				BK_READ: begin
					valid_q <= 1'b1;
					state_q <= BK_SEND;
				end
				BK_SEND: begin
					// advance straight to the next byte while the sink keeps taking
					if (out_acc) begin
						if (last) begin
							valid_q <= 1'b0;
							state_q <= BK_IDLE;
						end else begin
							pos_q <= pos_q + 6'd1;
						end
					end
				end
				default: begin
					valid_q <= 1'b0;
					state_q <= BK_IDLE;
				end
			endcase
		end
	end

	a_valid_send: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (state_q == BK_SEND))
		else $error("output valid outside the send state");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_SEND) |-> (pos_q < len_q))
		else $error("byte position beyond frame length");

	a_continue: assert property (@(posedge clk) disable iff (!arst_n)
		(out_acc && !last) |=> (m_tvalid && pos_q == $past(pos_q) + 6'd1))
		else $error("drain did not move to the next byte");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_wr.en && state_q != BK_IDLE) |-> (mem_wr.bank != bank_q))
		else $error("write into the bank being drained");

endmodule

`default_nettype wire

### test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: regression for sync_length_sum_deframer
// Feeds byte streams of good, corrupt and broken frames under several length
// windows, predicts the frame bytes that must come out, and compares each
// output request field by field while both stream sides idle at random.
// ----------------------------------------------------------------------------
module testbench;
	import sld_pkg::*;

	localparam int CLK_HALF     = 10;
	localparam int DRAIN_CYCLES = 8;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int PHASE_ITEMS  = 5;
	localparam int PREDICT      = -1;
	localparam int DIR_ROWS     = 27;

	typedef struct packed {
		logic [7:0] data;
		logic [5:0] pos;
		logic [5:0] len;
		logic       last;
	} frame_beat_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // [7:0] rx_byte
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;   // [7:0] frame_byte, [13:8] byte_pos, [19:14] total_len
	logic        m_tlast;
	logic        cfg_we;
	logic        cfg_addr;
	logic [6:0]  cfg_wdata;

	sync_length_sum_deframer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	// Predicted deframer state
	logic [5:0]  min_len_q;
	logic [6:0]  max_len_q;
	logic [1:0]  phase_q;
	logic [5:0]  fill_q;
	logic [5:0]  frame_len_q;
	logic [7:0]  sum_q;
	logic [7:0]  frame_buf [64];
	frame_beat_t beat_q [$];

	int failures;
	int cycle_count;
	bit src_calm;
	bit sink_calm;
	int stall_left;

	// Directed rows: a byte and the number of frame bytes it must release
	logic [7:0] dir_byte [DIR_ROWS] = '{
		8'h00,                                      // noise while hunting
		8'h5A, 8'h00,                               // bad second sync byte
		8'h5A, 8'h5A, 8'hA5, 8'h07,                 // second 5A is consumed, no resync
		8'h5A, 8'hA5, 8'h06,                        // length equal to min_len
		8'h5A, 8'hA5, 8'h40,                        // length equal to max_len
		8'h5A, 8'hA5, 8'h07, 8'hFF, 8'h00, 8'h80, 8'h85, // good frame
		8'h5A, 8'hA5, 8'h07, 8'h01, 8'h02, 8'h03, 8'h00  // checksum mismatch
	};
	int dir_beats [DIR_ROWS] = '{
		0,
		0, 0,
		0, 0, 0, 0,
		0, 0, 0,
		0, 0, 0,
		PREDICT, PREDICT, PREDICT, PREDICT, PREDICT, PREDICT, 7,
		0, 0, 0, 0, 0, 0, 0
	};

	task automatic hunt_reset();
		phase_q = PH_HUNT;
		fill_q = '0;
		frame_len_q = '0;
		sum_q = '0;
	endtask

	task automatic keep_byte(input logic [7:0] b);
		frame_buf[fill_q] = b;
		fill_q = fill_q + 6'd1;
	endtask

	// Advance the predicted parser by one byte and queue any released frame
	task automatic deframe_byte(input logic [7:0] b, output int n_beats);
		frame_beat_t beat;
		n_beats = 0;
		case (phase_q)
			PH_SECOND: begin
				if (b == SYNC_SECOND) begin
					keep_byte(b);
					sum_q = sum_q + b;
					phase_q = PH_LENGTH;
				end else begin
					hunt_reset();
				end
			end
			PH_LENGTH: begin
				if (b > min_len_q && b < max_len_q && b >= LEN_FLOOR && b <= LEN_CEIL) begin
					keep_byte(b);
					sum_q = sum_q + b;
					frame_len_q = b[5:0];
					phase_q = PH_BODY;
				end else begin
					hunt_reset();
				end
			end
			PH_BODY: begin
				keep_byte(b);
				if (fill_q < frame_len_q) begin
					sum_q = sum_q + b;
				end else if (sum_q != b) begin
					hunt_reset();
				end else begin
					for (int k = 0; k < frame_len_q; k++) begin
						beat.data = frame_buf[k];
						beat.pos = 6'(k);
						beat.len = frame_len_q;
						beat.last = (k + 1 == frame_len_q);
						beat_q.push_back(beat);
					end
					n_beats = int'(frame_len_q);
					hunt_reset();
				end
			end
			default: begin
				if (b == SYNC_FIRST) begin
					fill_q = '0;
					keep_byte(b);
					sum_q = b;
					phase_q = PH_SECOND;
				end else begin
					hunt_reset();
				end
			end
		endcase
	endtask

	// Mostly short gaps, a few long ones
	function automatic int pick_gap(input bit calm);
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic send_byte(input logic [7:0] b, output int n_beats);
		int gap;
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= b;
		do @(posedge clk); while (s_tready !== 1'b1);
		deframe_byte(b, n_beats);
		if ($urandom_range(0, 31) == 0)
			src_calm = !src_calm;
		gap = pick_gap(src_calm);
		if (gap > 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic write_reg(input logic addr, input logic [6:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= addr;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (addr == REG_MIN_LEN)
			min_len_q = val[5:0];
		else
			max_len_q = val;
	endtask

	// Drop the request line, then hold until every predicted byte has left
	task automatic wait_idle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (beat_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic random_traffic(input int budget);
		int sent, lo, hi, len, kind, n, floor_len, ceil_len;
		logic [7:0] sum, bad;
		sent = 0;
		floor_len = int'(LEN_FLOOR);
		ceil_len = int'(LEN_CEIL);
		lo = int'(min_len_q) + 1;
		lo = (lo > floor_len) ? lo : floor_len;
		hi = int'(max_len_q);
		hi = (hi - 1 < ceil_len) ? hi - 1 : ceil_len;
		while (sent < budget) begin
			kind = $urandom_range(0, 9);
			if (kind == 0) begin
				// line noise, ignored while hunting
				bad = 8'($urandom_range(0, 255));
				if (bad == SYNC_FIRST)
					bad = 8'h00;
				send_byte(bad, n);
				sent += 1;
			end else if (kind == 1) begin
				bad = 8'($urandom_range(0, 255));
				if (bad == SYNC_SECOND)
					bad = 8'h00;
				send_byte(SYNC_FIRST, n);
				send_byte(bad, n);
				sent += 2;
			end else if (kind == 2 || lo > hi) begin
				do bad = 8'($urandom_range(0, 255)); while (bad >= lo && bad <= hi);
				send_byte(SYNC_FIRST, n);
				send_byte(SYNC_SECOND, n);
				send_byte(bad, n);
				sent += 3;
			end else begin
				// keep most frames short
				if ($urandom_range(0, 15) == 0)
					len = hi;
				else
					len = $urandom_range(lo, (hi < lo + 6) ? hi : lo + 6);
				sum = 8'h00;
				for (int k = 0; k < len - 1; k++) begin
					logic [7:0] v;
					if (k == 0)
						v = SYNC_FIRST;
					else if (k == 1)
						v = SYNC_SECOND;
					else if (k == 2)
						v = 8'(len);
					else
						v = 8'($urandom_range(0, 255));
					sum = sum + v;
					send_byte(v, n);
				end
				if ($urandom_range(0, 7) == 0)
					sum = sum ^ 8'($urandom_range(1, 255));
				send_byte(sum, n);
				sent += len;
			end
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			failures++;
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("sync_length_sum_deframer regression: fail");
			$finish;
		end
	end

	// Output side: random stalls with calm stretches
	initial begin
		m_tready = 1'b0;
		stall_left = 0;
		sink_calm = 1'b0;
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 47) == 0)
				sink_calm = !sink_calm;
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if (!sink_calm && $urandom_range(0, 5) == 0)
					stall_left = pick_gap(1'b0);
			end
		end
	end

	always @(posedge clk) begin : beat_check
		frame_beat_t want;
		if (arst_n && m_tvalid === 1'b1 && m_tready) begin
			if (beat_q.size() == 0) begin
				$error("frame_byte: expected none, got %0d", m_tdata[7:0]);
				failures++;
			end else begin
				want = beat_q.pop_front();
				check_field("frame_byte", 32'(want.data), 32'(m_tdata[7:0]));
				check_field("byte_pos", 32'(want.pos), 32'(m_tdata[13:8]));
				check_field("total_len", 32'(want.len), 32'(m_tdata[19:14]));
				check_field("tdata_pad", 32'd0, 32'(m_tdata[23:20]));
				check_field("last_byte", 32'(want.last), 32'(m_tlast));
			end
		end
	end

	initial begin : stimulus
		int n, mn, mx;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_we = 1'b0;
		cfg_addr = REG_MIN_LEN;
		cfg_wdata = '0;
		failures = 0;
		cycle_count = 0;
		src_calm = 1'b0;
		min_len_q = MIN_LEN_RST;
		max_len_q = MAX_LEN_RST;
		hunt_reset();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < DIR_ROWS; i++) begin
			send_byte(dir_byte[i], n);
			if (dir_beats[i] != PREDICT && n != dir_beats[i]) begin
				$error("released bytes: expected %0d, got %0d", dir_beats[i], n);
				failures++;
			end
		end

		for (int p = 0; p < 6; p++) begin
			if (p > 0) begin
				wait_idle();
				case (p)
					1: begin mn = 3;  mx = 5;   end  // only length 4 passes
					2: begin mn = 62; mx = 64;  end  // only length 63 passes
					3: begin mn = 0;  mx = 127; end  // fixed floor and ceiling rule
					4: begin mn = 3;  mx = 64;  end
					default: begin
						mn = $urandom_range(3, 40);
						mx = $urandom_range(mn + 3, 64);
					end
				endcase
				write_reg(REG_MIN_LEN, 7'(mn));
				write_reg(REG_MAX_LEN, 7'(mx));
			end
			random_traffic(PHASE_ITEMS);
		end

		wait_idle();
		if (failures == 0)
			$display("sync_length_sum_deframer regression: pass");
		else
			$display("sync_length_sum_deframer regression: fail");
		$finish;
	end

endmodule
